// ===== sv/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the PID position servo
// Register indexes, fixed field widths, controller command and status types.
// ----------------------------------------------------------------------------
package pps_pkg;

    // fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;
    localparam int WIN_W      = 12;
    localparam int DEG_W      = 9;
    localparam int ERR_W      = 13;
    localparam int DERR_W     = ERR_W + 1;
    localparam int SUM_W      = 20;

    // angle scale divisor
    localparam int DEG_AT_REF = 90;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_INTEG_GAIN   = 3'd2,
        REG_REF_ZERO     = 3'd3,
        REG_REF_NINETY   = 3'd4,
        REG_INTEG_WINDOW = 3'd5
    } reg_idx_t;

    // shared multiplier operand selection
    typedef enum logic [1:0] {
        MUL_TGT = 2'd0,
        MUL_P   = 2'd1,
        MUL_D   = 2'd2,
        MUL_I   = 2'd3
    } mul_sel_t;

    // drive accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB  = 2'd2,
        ACC_ADD  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        logic     div_step;
        mul_sel_t mul_sel;
        logic     err_commit;
        acc_op_t  acc_op;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/pps_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_regs: configuration register file
// Holds gains, sensor reference points and integral window; flags writes to
// the reference points so the angle scale gets recomputed.
// ----------------------------------------------------------------------------
module pps_regs #(
    parameter int SENSOR_BITS = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pps_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [pps_pkg::GAIN_W-1:0]          prop_gain,
    output logic [pps_pkg::GAIN_W-1:0]          deriv_gain,
    output logic [pps_pkg::GAIN_W-1:0]          integ_gain,
    output logic [SENSOR_BITS-1:0]              ref_zero,
    output logic [SENSOR_BITS-1:0]              ref_ninety,
    output logic [pps_pkg::WIN_W-1:0]           integ_window,
    output logic                                ref_write
);

    logic [pps_pkg::GAIN_W-1:0] prop_gain_reg, deriv_gain_reg, integ_gain_reg;
    logic [SENSOR_BITS-1:0]     ref_zero_reg, ref_ninety_reg;
    logic [pps_pkg::WIN_W-1:0]  integ_window_reg;
    logic                       wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid;

    // flag a reference point write
    assign ref_write = wr_en &&
        ((cfg_index == pps_pkg::REG_REF_ZERO) || (cfg_index == pps_pkg::REG_REF_NINETY));

    // decode and store register writes, drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg    <= '0;
            deriv_gain_reg   <= '0;
            integ_gain_reg   <= '0;
            ref_zero_reg     <= '0;
            ref_ninety_reg   <= '0;
            integ_window_reg <= pps_pkg::WINDOW_RESET;
        end else if (wr_en) begin
            unique case (cfg_index)
                pps_pkg::REG_PROP_GAIN:    prop_gain_reg    <= cfg_data[pps_pkg::GAIN_W-1:0];
                pps_pkg::REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data[pps_pkg::GAIN_W-1:0];
                pps_pkg::REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[pps_pkg::GAIN_W-1:0];
                pps_pkg::REG_REF_ZERO:     ref_zero_reg     <= cfg_data[SENSOR_BITS-1:0];
                pps_pkg::REG_REF_NINETY:   ref_ninety_reg   <= cfg_data[SENSOR_BITS-1:0];
                pps_pkg::REG_INTEG_WINDOW: integ_window_reg <= cfg_data[pps_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign prop_gain    = prop_gain_reg;
    assign deriv_gain   = deriv_gain_reg;
    assign integ_gain   = integ_gain_reg;
    assign ref_zero     = ref_zero_reg;
    assign ref_ninety   = ref_ninety_reg;
    assign integ_window = integ_window_reg;

endmodule
`default_nettype wire

// ===== sv/pps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ctrl: sequencer of the PID position servo
// Steps the datapath through scale division, target, error and the three
// gain products on one shared multiplier, then loads the output register.
// ----------------------------------------------------------------------------
module pps_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire logic          ref_write,
    input  wire pps_pkg::dp_status_t status,
    output pps_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCALE = 9'b000000010,
        ST_TGT   = 9'b000000100,
        ST_ERR   = 9'b000001000,
        ST_MP    = 9'b000010000,
        ST_MD    = 9'b000100000,
        ST_MI    = 9'b001000000,
        ST_ACC   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE) && !pend_reg;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = pps_pkg::MUL_TGT;
        cmd.acc_op  = pps_pkg::ACC_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (pend_reg) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SCALE;
                end else if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_TGT;
                end
            end
            ST_SCALE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TGT: begin
                cmd.mul_sel = pps_pkg::MUL_TGT;
                state_next  = ST_ERR;
            end
            ST_ERR: begin
                cmd.err_commit = 1'b1;
                state_next     = ST_MP;
            end
            ST_MP: begin
                cmd.mul_sel = pps_pkg::MUL_P;
                state_next  = ST_MD;
            end
            ST_MD: begin
                cmd.mul_sel = pps_pkg::MUL_D;
                cmd.acc_op  = pps_pkg::ACC_LOAD;
                state_next  = ST_MI;
            end
            ST_MI: begin
                cmd.mul_sel = pps_pkg::MUL_I;
                cmd.acc_op  = pps_pkg::ACC_SUB;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_op = pps_pkg::ACC_ADD;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // hold a scale recompute request until the divider starts
    assign pend_next = ref_write || (pend_reg && !cmd.div_start);

    // output valid: set on load, drop when taken
    assign m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== sv/pps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_dp: datapath of the PID position servo
// Reciprocal scale divider, one shared signed multiplier with a product
// register, error and integral update, drive accumulator, clamp and split.
// ----------------------------------------------------------------------------
module pps_dp #(
    parameter int SENSOR_BITS    = 10,
    parameter int DRIVE_BITS     = 8,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire pps_pkg::ctrl_cmd_t               cmd,
    output pps_pkg::dp_status_t                   status,
    input  wire logic signed [pps_pkg::DEG_W-1:0] in_target_deg,
    input  wire logic [SENSOR_BITS-1:0]           in_sensor_pos,
    input  wire logic [DRIVE_BITS-1:0]            in_max_drive,
    input  wire logic [pps_pkg::GAIN_W-1:0]       prop_gain,
    input  wire logic [pps_pkg::GAIN_W-1:0]       deriv_gain,
    input  wire logic [pps_pkg::GAIN_W-1:0]       integ_gain,
    input  wire logic [SENSOR_BITS-1:0]           ref_zero,
    input  wire logic [SENSOR_BITS-1:0]           ref_ninety,
    input  wire logic [pps_pkg::WIN_W-1:0]        integ_window,
    output logic [DRIVE_BITS-1:0]                 out_drive_fwd,
    output logic [DRIVE_BITS-1:0]                 out_drive_rev
);

    localparam int ERR_W  = pps_pkg::ERR_W;
    localparam int DERR_W = pps_pkg::DERR_W;
    localparam int SUM_W  = pps_pkg::SUM_W;
    // dividend and scale widths; |scale| < 2^(SENSOR_BITS+GAIN_FRAC_BITS-6)
    localparam int DVW    = SENSOR_BITS + GAIN_FRAC_BITS;
    localparam int SW     = SENSOR_BITS + GAIN_FRAC_BITS - 5;
    // reciprocal of 90 with enough fraction bits for an exact quotient
    localparam int RK     = DVW + 7;
    localparam int RW     = DVW + 1;
    // multiplier operand and product widths
    localparam int MA     = (SW > pps_pkg::GAIN_W + 1) ? SW : pps_pkg::GAIN_W + 1;
    localparam int MB     = SUM_W;
    localparam int PW     = MA + MB;
    localparam int AW     = PW + 2;
    localparam int EW     = PW + 2;

    localparam logic signed [PW-1:0] ROUND_ADJ = PW'((2 ** GAIN_FRAC_BITS) - 1);
    localparam logic signed [EW-1:0] ERR_HI = EW'((2 ** (ERR_W - 1)) - 1);
    localparam logic signed [EW-1:0] ERR_LO = EW'(-(2 ** (ERR_W - 1)));
    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W + 1)'((2 ** (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SUM_LO = (SUM_W + 1)'(-(2 ** (SUM_W - 1)));
    localparam logic [RW-1:0] RECIP = RW'(((longint'(1) << RK)
        + longint'(pps_pkg::DEG_AT_REF - 1)) / longint'(pps_pkg::DEG_AT_REF));

    // ---------------- scale divider ----------------
    logic signed [SENSOR_BITS:0] ref_diff;
    logic [SENSOR_BITS-1:0]      ref_mag;
    logic [DVW-1:0]              dvd_reg;
    logic [DVW+RW-1:0]           rq_reg;
    logic [SW-2:0]               quo;
    logic                        phase_reg;
    logic                        neg_reg;
    logic signed [SW-1:0]        scale_reg, scale_mag;

    assign ref_diff = $signed({1'b0, ref_ninety}) - $signed({1'b0, ref_zero});
    assign ref_mag  = ref_diff[SENSOR_BITS] ? SENSOR_BITS'(-ref_diff)
                                            : ref_diff[SENSOR_BITS-1:0];

    // quotient is the top bits of the magnitude times the reciprocal
    assign quo       = rq_reg[RK +: SW-1];
    assign scale_mag = $signed({1'b0, quo});

    assign status.div_last = phase_reg;

    // latch the magnitude, then multiply by the reciprocal
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg   <= {ref_mag, {GAIN_FRAC_BITS{1'b0}}};
            neg_reg   <= ref_diff[SENSOR_BITS];
            phase_reg <= 1'b0;
        end else if (cmd.div_step) begin
            rq_reg    <= dvd_reg * RECIP;
            phase_reg <= 1'b1;
        end
    end

    // store the signed scale once the product is in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= '0;
        end else if (cmd.div_step && status.div_last) begin
            scale_reg <= neg_reg ? -scale_mag : scale_mag;
        end
    end

    // ---------------- input capture ----------------
    logic signed [pps_pkg::DEG_W-1:0] deg_reg;
    logic [SENSOR_BITS-1:0]           pos_reg;
    logic [DRIVE_BITS-1:0]            lim_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            deg_reg <= in_target_deg;
            pos_reg <= in_sensor_pos;
            lim_reg <= in_max_drive;
        end
    end

    // ---------------- shared multiplier ----------------
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [SUM_W-1:0]  err_sum_reg;
    logic signed [DERR_W-1:0] derr_reg;
    logic signed [MA-1:0]     op_a;
    logic signed [MB-1:0]     op_b;
    logic signed [PW-1:0]     prod_reg, prod_bias, prod_tr;

    always_comb begin
        unique case (cmd.mul_sel)
            pps_pkg::MUL_TGT: begin
                op_a = MA'(scale_reg);
                op_b = MB'(deg_reg);
            end
            pps_pkg::MUL_P: begin
                op_a = $signed(MA'(prop_gain));
                op_b = MB'(last_err_reg);
            end
            pps_pkg::MUL_D: begin
                op_a = $signed(MA'(deriv_gain));
                op_b = MB'(derr_reg);
            end
            pps_pkg::MUL_I: begin
                op_a = $signed(MA'(integ_gain));
                op_b = MB'(err_sum_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    // scale down, truncating toward zero
    assign prod_bias = prod_reg + (prod_reg[PW-1] ? ROUND_ADJ : PW'(0));
    assign prod_tr   = prod_bias >>> GAIN_FRAC_BITS;

    // ---------------- error and integral ----------------
    logic signed [EW-1:0]     err_wide;
    logic signed [ERR_W-1:0]  err_sat;
    logic signed [ERR_W:0]    err_ext, err_abs;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat, sum_next;
    logic signed [DERR_W-1:0] derr_next;

    assign err_wide = EW'(prod_tr) + EW'($signed({1'b0, ref_zero}))
                    - EW'($signed({1'b0, pos_reg}));

    always_comb begin
        priority if (err_wide > ERR_HI) begin
            err_sat = ERR_HI[ERR_W-1:0];
        end else if (err_wide < ERR_LO) begin
            err_sat = ERR_LO[ERR_W-1:0];
        end else begin
            err_sat = err_wide[ERR_W-1:0];
        end
    end

    assign derr_next = DERR_W'(err_sat) - DERR_W'(last_err_reg);
    assign sum_wide  = (SUM_W + 1)'(err_sum_reg) + (SUM_W + 1)'(err_sat);

    always_comb begin
        priority if (sum_wide > SUM_HI) begin
            sum_sat = SUM_HI[SUM_W-1:0];
        end else if (sum_wide < SUM_LO) begin
            sum_sat = SUM_LO[SUM_W-1:0];
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // clear the integral outside the window
    assign err_ext  = (ERR_W + 1)'(err_sat);
    assign err_abs  = err_ext[ERR_W] ? -err_ext : err_ext;
    assign sum_next = ($unsigned(err_abs) > (ERR_W + 1)'(integ_window)) ? '0 : sum_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            err_sum_reg  <= '0;
        end else if (cmd.err_commit) begin
            last_err_reg <= err_sat;
            err_sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_commit) begin
            derr_reg <= derr_next;
        end
    end

    // ---------------- drive accumulator ----------------
    logic signed [AW-1:0] acc_reg, acc_next, term;

    assign term = AW'(prod_tr);

    always_comb begin
        unique case (cmd.acc_op)
            pps_pkg::ACC_HOLD: acc_next = acc_reg;
            pps_pkg::ACC_LOAD: acc_next = term;
            pps_pkg::ACC_SUB:  acc_next = acc_reg - term;
            pps_pkg::ACC_ADD:  acc_next = acc_reg + term;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // ---------------- clamp and split by sign ----------------
    logic signed [AW-1:0]  lim_ext, acc_neg;
    logic [DRIVE_BITS-1:0] fwd_next, rev_next;
    logic [DRIVE_BITS-1:0] fwd_reg, rev_reg;

    assign lim_ext = AW'($signed({1'b0, lim_reg}));
    assign acc_neg = -acc_reg;

    always_comb begin
        fwd_next = '0;
        rev_next = '0;
        if (acc_reg > AW'(0)) begin
            fwd_next = (acc_reg > lim_ext) ? lim_reg : acc_reg[DRIVE_BITS-1:0];
        end else begin
            rev_next = (acc_neg > lim_ext) ? lim_reg : acc_neg[DRIVE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

    assign out_drive_fwd = fwd_reg;
    assign out_drive_rev = rev_reg;

endmodule
`default_nettype wire

// ===== sv/pid_position_servo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_servo: PID position controller with windowed integral
// Usage:
//   s_ channel: one control tick (target angle, sensor position, drive limit).
//   m_ channel: one result per tick, PWM duties for the forward and reverse pin.
//   cfg channel: register writes (index, data), taken in every cycle.
// A tick is accepted only in idle; the sequencer then steps target, error and
//   the three gain products through one shared multiplier, then accumulate and
//   output, before m_valid rises and it returns to idle for the next tick.
// The result sits in an output register; the next tick is accepted while it
//   waits, and the sequencer holds before its output step if the receiver
//   stalls with the previous result still pending.
// A write to ref_zero or ref_ninety recomputes the angle scale by a reciprocal
//   multiply: the request is registered, the divider latches the magnitude and
//   then multiplies, and s_ready stays low until the scale is stored.
// Reset clears the error history, integral and registers (integ_window to 10)
//   and needs no further pass: the block is ready the next cycle.
// ----------------------------------------------------------------------------
module pid_position_servo #(
    parameter int SENSOR_BITS    = 10,
    parameter int DRIVE_BITS     = 8,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [pps_pkg::DEG_W-1:0] s_target_deg,
    input  wire logic [SENSOR_BITS-1:0]           s_sensor_pos,
    input  wire logic [DRIVE_BITS-1:0]            s_max_drive,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [DRIVE_BITS-1:0]                 m_drive_fwd,
    output logic [DRIVE_BITS-1:0]                 m_drive_rev,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [pps_pkg::GAIN_W-1:0] prop_gain, deriv_gain, integ_gain;
    logic [SENSOR_BITS-1:0]     ref_zero, ref_ninety;
    logic [pps_pkg::WIN_W-1:0]  integ_window;
    logic                       ref_write;
    pps_pkg::ctrl_cmd_t         cmd;
    pps_pkg::dp_status_t        status;

    // configuration registers
    pps_regs #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .prop_gain    (prop_gain),
        .deriv_gain   (deriv_gain),
        .integ_gain   (integ_gain),
        .ref_zero     (ref_zero),
        .ref_ninety   (ref_ninety),
        .integ_window (integ_window),
        .ref_write    (ref_write)
    );

    // sequencer
    pps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .ref_write (ref_write),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    pps_dp #(
        .SENSOR_BITS    (SENSOR_BITS),
        .DRIVE_BITS     (DRIVE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_target_deg (s_target_deg),
        .in_sensor_pos (s_sensor_pos),
        .in_max_drive  (s_max_drive),
        .prop_gain     (prop_gain),
        .deriv_gain    (deriv_gain),
        .integ_gain    (integ_gain),
        .ref_zero      (ref_zero),
        .ref_ninety    (ref_ninety),
        .integ_window  (integ_window),
        .out_drive_fwd (m_drive_fwd),
        .out_drive_rev (m_drive_rev)
    );

endmodule
`default_nettype wire

// ===== dv/servo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_checker: duty predictor and scoreboard for the PID position servo
// Tracks register writes, predicts the forward and reverse duty of every
// accepted tick from its own copy of the gains, error history and integral,
// and compares each returned result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module servo_checker #(
    parameter int SENSOR_BITS    = 10,
    parameter int DRIVE_BITS     = 8,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic signed [pps_pkg::DEG_W-1:0]      s_target_deg,
    input  logic [SENSOR_BITS-1:0]                s_sensor_pos,
    input  logic [DRIVE_BITS-1:0]                 s_max_drive,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [DRIVE_BITS-1:0]                 m_drive_fwd,
    input  logic [DRIVE_BITS-1:0]                 m_drive_rev,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [pps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]        cfg_data,
    output int                                    fault_count,
    output int                                    pending,
    output int                                    ticks_seen,
    output int                                    duties_seen
);

    localparam int     ERR_W  = pps_pkg::ERR_W;
    localparam int     SUM_W  = pps_pkg::SUM_W;
    localparam longint FX_ONE = longint'(1) << GAIN_FRAC_BITS;
    localparam longint ERR_HI = (longint'(1) << (ERR_W - 1)) - 1;
    localparam longint ERR_LO = -(longint'(1) << (ERR_W - 1));
    localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

    typedef struct packed {
        logic [DRIVE_BITS-1:0] fwd;
        logic [DRIVE_BITS-1:0] rev;
    } duty_t;

    duty_t duty_q[$];

    // register copy
    logic [pps_pkg::GAIN_W-1:0] kp;
    logic [pps_pkg::GAIN_W-1:0] kd;
    logic [pps_pkg::GAIN_W-1:0] ki;
    logic [SENSOR_BITS-1:0]     zero_cnt;
    logic [SENSOR_BITS-1:0]     ninety_cnt;
    logic [pps_pkg::WIN_W-1:0]  window;

    // controller history
    logic signed [ERR_W-1:0] prev_err;
    logic signed [SUM_W-1:0] err_sum;

    int faults  = 0;
    int ticks   = 0;
    int duties  = 0;

    task automatic flag_fault(input string what);
        $display("servo_checker: %s", what);
        faults++;
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the error history by one tick and return the duty pair it yields.
    function automatic duty_t next_duty(input logic signed [pps_pkg::DEG_W-1:0] deg,
                                        input logic [SENSOR_BITS-1:0] pos,
                                        input logic [DRIVE_BITS-1:0] lim);
        longint scale;
        longint aim;
        longint err;
        longint derr;
        longint sum;
        longint drive;
        longint cap;
        duty_t  d;
        // degrees to counts, scale and product both truncated toward zero
        scale = (longint'(ninety_cnt) - longint'(zero_cnt)) * FX_ONE / pps_pkg::DEG_AT_REF;
        aim   = scale * longint'(deg) / FX_ONE + longint'(zero_cnt);
        err   = clamp(aim - longint'(pos), ERR_LO, ERR_HI);
        derr  = err - longint'(prev_err);
        // integral saturates, and is dropped outside the window
        sum   = clamp(longint'(err_sum) + err, SUM_LO, SUM_HI);
        if (((err < 0) ? -err : err) > longint'(window)) begin
            sum = 0;
        end
        drive = longint'(kp) * err / FX_ONE
              - longint'(kd) * derr / FX_ONE
              + longint'(ki) * sum / FX_ONE;
        prev_err = ERR_W'(err);
        err_sum  = SUM_W'(sum);
        // limit and split by sign
        cap   = longint'(lim);
        drive = clamp(drive, -cap, cap);
        if (drive > 0) begin
            d.fwd = DRIVE_BITS'(drive);
            d.rev = '0;
        end else begin
            d.fwd = '0;
            d.rev = DRIVE_BITS'(-drive);
        end
        return d;
    endfunction

    always @(posedge aclk) begin
        duty_t want;
        if (!aresetn) begin
            kp         = '0;
            kd         = '0;
            ki         = '0;
            zero_cnt   = '0;
            ninety_cnt = '0;
            window     = pps_pkg::WINDOW_RESET;
            prev_err   = '0;
            err_sum    = '0;
            duty_q.delete();
        end else begin
            // apply register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pps_pkg::REG_PROP_GAIN:    kp         = cfg_data;
                    pps_pkg::REG_DERIV_GAIN:   kd         = cfg_data;
                    pps_pkg::REG_INTEG_GAIN:   ki         = cfg_data;
                    pps_pkg::REG_REF_ZERO:     zero_cnt   = cfg_data[SENSOR_BITS-1:0];
                    pps_pkg::REG_REF_NINETY:   ninety_cnt = cfg_data[SENSOR_BITS-1:0];
                    pps_pkg::REG_INTEG_WINDOW: window     = cfg_data[pps_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end
            // retire the oldest prediction against the returned duty
            if (m_valid && m_ready) begin
                duties++;
                if (duty_q.size() == 0) begin
                    flag_fault($sformatf("duty %0d returned with no tick outstanding", duties));
                end else begin
                    want = duty_q.pop_front();
                    if (m_drive_fwd !== want.fwd) begin
                        flag_fault($sformatf("duty %0d fwd got %0d want %0d",
                                             duties, m_drive_fwd, want.fwd));
                    end
                    if (m_drive_rev !== want.rev) begin
                        flag_fault($sformatf("duty %0d rev got %0d want %0d",
                                             duties, m_drive_rev, want.rev));
                    end
                end
            end
            // predict the accepted request
            if (s_valid && s_ready) begin
                duty_q.push_back(next_duty(s_target_deg, s_sensor_pos, s_max_drive));
                ticks++;
            end
        end
        fault_count <= faults;
        pending     <= duty_q.size();
        ticks_seen  <= ticks;
        duties_seen <= duties;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the PID position servo
// Drives directed and random control ticks over several register settings,
// with random sender gaps and receiver stalls; the checker beside the block
// predicts every duty and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int SENSOR_BITS    = 10;
    localparam int DRIVE_BITS     = 8;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_TICKS    = 170;
    localparam int DEG_W          = pps_pkg::DEG_W;
    localparam int CFG_IDX_W      = pps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = pps_pkg::CFG_DATA_W;

    // indexes past the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_valid      = 1'b0;
    logic signed [DEG_W-1:0]       s_target_deg = '0;
    logic [SENSOR_BITS-1:0]        s_sensor_pos = '0;
    logic [DRIVE_BITS-1:0]         s_max_drive  = '0;
    logic                          m_ready      = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;
    logic                          s_ready;
    logic                          m_valid;
    logic                          cfg_ready;
    logic [DRIVE_BITS-1:0]         m_drive_fwd;
    logic [DRIVE_BITS-1:0]         m_drive_rev;

    int fault_count;
    int pending;
    int ticks_seen;
    int duties_seen;
    int snd_idle_pct    = 0;
    int rcv_idle_pct    = 0;
    int settings_loaded = 0;
    int cycles          = 0;

    always #6 aclk = ~aclk;

    pid_position_servo #(
        .SENSOR_BITS    (SENSOR_BITS),
        .DRIVE_BITS     (DRIVE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_target_deg (s_target_deg),
        .s_sensor_pos (s_sensor_pos),
        .s_max_drive  (s_max_drive),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive_fwd  (m_drive_fwd),
        .m_drive_rev  (m_drive_rev),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    servo_checker #(
        .SENSOR_BITS    (SENSOR_BITS),
        .DRIVE_BITS     (DRIVE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_target_deg (s_target_deg),
        .s_sensor_pos (s_sensor_pos),
        .s_max_drive  (s_max_drive),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive_fwd  (m_drive_fwd),
        .m_drive_rev  (m_drive_rev),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fault_count  (fault_count),
        .pending      (pending),
        .ticks_seen   (ticks_seen),
        .duties_seen  (duties_seen)
    );

    // stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= (rcv_idle_pct == 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // give up on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // All tasks start and end at a falling edge with nothing yet assigned there.

    task automatic stop_ticks();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending != 0) begin
            @(negedge aclk);
        end
    endtask

    // Issue one control tick, leave valid high after acceptance.
    task automatic send_tick(input int deg, input int pos, input int lim);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_target_deg <= DEG_W'(deg);
        s_sensor_pos <= SENSOR_BITS'(pos);
        s_max_drive  <= DRIVE_BITS'(lim);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Quiesce the block, then rewrite every register.
    task automatic load_setting(input int kp, input int kd, input int ki,
                                input int zero_cnt, input int ninety_cnt, input int win);
        stop_ticks();
        wait_drained();
        write_reg(pps_pkg::REG_PROP_GAIN, kp);
        write_reg(pps_pkg::REG_DERIV_GAIN, kd);
        write_reg(pps_pkg::REG_INTEG_GAIN, ki);
        write_reg(pps_pkg::REG_REF_ZERO, zero_cnt);
        write_reg(pps_pkg::REG_REF_NINETY, ninety_cnt);
        write_reg(pps_pkg::REG_INTEG_WINDOW, win);
        settings_loaded++;
    endtask

    task automatic load_random_setting();
        load_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    // Bursts of either fully random ticks or a held target with a sensor that stays
    // at or jitters around one spot, so the integral builds up, saturates or clears.
    task automatic run_phase(input int n, input int snd_pct, input int rcv_pct);
        int   left;
        int   burst;
        int   mode;
        int   jitter;
        int   deg;
        int   pos_base;
        int   lim;
        logic paused;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        left   = n;
        paused = 1'b0;
        while (left > 0) begin
            burst = $urandom_range(4, 200);
            if (burst > left) begin
                burst = left;
            end
            mode     = $urandom_range(0, 3);
            jitter   = (mode == 1) ? 0 : ((mode == 2) ? 4 : 64);
            deg      = $urandom_range(0, 511);
            pos_base = $urandom_range(0, 1023);
            lim      = $urandom_range(0, 255);
            repeat (burst) begin
                if (mode == 0) begin
                    send_tick($urandom_range(0, 511), $urandom_range(0, 1023),
                              $urandom_range(0, 255));
                end else begin
                    send_tick(deg, pos_base + $urandom_range(0, 2 * jitter) - jitter,
                              ($urandom_range(0, 1) == 0) ? 255 : lim);
                end
            end
            left -= burst;
            // after the first burst, and then at random, hold off until every outstanding duty is back
            if (!paused || $urandom_range(0, 3) == 0) begin
                stop_ticks();
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: all gains zero, every duty zero
        snd_idle_pct = 0;
        rcv_idle_pct = 50;
        send_tick(0, 0, 255);
        send_tick(-180, 1023, 255);
        send_tick(180, 5, 255);

        // extreme gains, negative angle scale, widest window
        load_setting(65535, 65535, 65535, 1023, 0, 4095);
        write_reg(REG_SPARE_LO, 0);
        write_reg(REG_SPARE_HI, 0);
        send_tick(-256, 0, 255);
        send_tick(255, 1023, 255);
        send_tick(255, 0, 255);
        send_tick(-256, 1023, 255);
        send_tick(180, 512, 255);
        send_tick(-180, 512, 255);
        send_tick(0, 1023, 0);
        send_tick(0, 0, 0);
        send_tick(1, 1023, 1);
        send_tick(-1, 0, 128);
        send_tick(200, 0, 255);
        send_tick(-200, 1023, 255);
        send_tick(90, 600, 255);
        send_tick(0, 0, 255);

        // moderate gains around a target of 449 counts at 45 degrees
        load_setting(16'h0100, 16'h0080, 16'h0040, 200, 700, 20);
        send_tick(45, 449, 255);
        send_tick(45, 445, 255);
        send_tick(45, 453, 255);
        send_tick(45, 449, 255);
        send_tick(45, 460, 255);
        send_tick(45, 100, 255);
        send_tick(45, 440, 3);
        send_tick(45, 458, 3);

        // random traffic over several settings and idle patterns
        load_setting(16'h0180, 16'h0100, 16'h0010, 300, 900, 64);
        run_phase(PHASE_TICKS, 23, 84);
        load_random_setting();
        run_phase(PHASE_TICKS, 23, 84);
        load_setting(0, 65535, 65535, 0, 1023, 0);
        run_phase(PHASE_TICKS, 84, 23);
        load_random_setting();
        run_phase(PHASE_TICKS, 84, 23);
        load_setting(1, 0, 1, 1023, 1023, 4095);
        run_phase(PHASE_TICKS, 0, 0);
        load_random_setting();
        run_phase(PHASE_TICKS, 0, 0);

        // drain and let the pipeline settle
        stop_ticks();
        wait_drained();
        repeat (16) @(negedge aclk);

        $display("tb: %0d ticks over %0d register settings, %0d duties compared",
                 ticks_seen, settings_loaded, duties_seen);
        $display("tb: angle and sensor extremes, reversed scale, zero limits, steady-error runs");
        if (fault_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pps_pkg.sv
sv/pps_regs.sv
sv/pps_ctrl.sv
sv/pps_dp.sv
sv/pid_position_servo.sv
dv/servo_checker.sv
dv/tb.sv
